[hw/rtl/lvm_pkg.sv]
// Shared constants and helpers for the look-at view matrix pipeline.
`default_nettype none

package lvm_pkg;

	// Fraction bits of the fixed-point format (Q16.16 by default)
	localparam int FRAC_BITS_DEF = 16;

	// Row numbers of the emitted matrix
	localparam logic [1:0] ROW_0 = 2'd0;
	localparam logic [1:0] ROW_1 = 2'd1;
	localparam logic [1:0] ROW_2 = 2'd2;
	localparam logic [1:0] ROW_3 = 2'd3;

	// Spacing counter reload after an accepted item; busy holds until it counts down to zero
	localparam logic [1:0] GAP_LAST = 2'd3;

	// Latency of one vector normalizer, input register to output register
	function automatic int unit_lat(input int frac);
		return 46 + frac;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/lvm_unit3.sv]
// Pipelined 3-vector normalizer: align, square-sum, bitwise isqrt, restoring divide.
`default_nettype none

module lvm_unit3 #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
	parameter int IW        = 33
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_vld,
	input  wire logic signed [IW-1:0]        vx,
	input  wire logic signed [IW-1:0]        vy,
	input  wire logic signed [IW-1:0]        vz,
	output logic                             out_vld,
	output logic                             out_ok,
	output logic signed [FRAC_BITS+1:0]      ux,
	output logic signed [FRAC_BITS+1:0]      uy,
	output logic signed [FRAC_BITS+1:0]      uz
);

	localparam int MW  = 64;            // magnitude word
	localparam int AW  = 31;            // aligned magnitude
	localparam int SW  = 64;            // sum of squares
	localparam int RW  = 32;            // root
	localparam int LVL = 6;             // log2(MW) shift levels
	localparam int DW  = FRAC_BITS + 32; // dividend
	localparam int QW  = FRAC_BITS + 1;
	localparam int UW  = FRAC_BITS + 2;
	localparam int DS  = FRAC_BITS + 1;

	logic signed [IW-1:0] vin [3];
	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	// stage 1: magnitudes and signs
	logic [MW-1:0] m_s1 [3];
	logic [2:0]    neg_s1;
	logic          vld_s1;

	for (genvar i = 0; i < 3; i++) begin : g_abs
		logic [IW:0] ext;
		logic [IW:0] mag;
		assign ext = {vin[i][IW-1], vin[i]};
		assign mag = vin[i][IW-1] ? (~ext + 1'b1) : ext;
		always_ff @(posedge clk) begin
			m_s1[i]   <= {{(MW-IW-1){1'b0}}, mag};
			neg_s1[i] <= vin[i][IW-1];
		end
	end

	// stage 2: max of first pair
	logic [MW-1:0] m_s2 [3];
	logic [MW-1:0] mx_s2;
	logic [2:0]    neg_s2;
	logic          vld_s2;

	always_ff @(posedge clk) begin
		m_s2   <= m_s1;
		mx_s2  <= (m_s1[0] > m_s1[1]) ? m_s1[0] : m_s1[1];
		neg_s2 <= neg_s1;
	end

	// normalize stages: index 0 = overall max, then one shift level per stage
	logic [MW-1:0] nm_s  [LVL+1][3];
	logic [MW-1:0] nmx_s [LVL+1];
	logic [2:0]    nneg_s [LVL+1];
	logic          nzero_s [LVL+1];
	logic          nvld_s [LVL+1];

	always_ff @(posedge clk) begin
		nm_s[0]    <= m_s2;
		nmx_s[0]   <= (mx_s2 > m_s2[2]) ? mx_s2 : m_s2[2];
		nneg_s[0]  <= neg_s2;
		nzero_s[0] <= (mx_s2 == '0) && (m_s2[2] == '0);
	end

	for (genvar j = 1; j <= LVL; j++) begin : g_nrm
		localparam int SH = 1 << (LVL - j);
		logic hit;
		assign hit = (nmx_s[j-1][MW-1 -: SH] == '0);
		always_ff @(posedge clk) begin
			nmx_s[j]   <= hit ? (nmx_s[j-1] << SH) : nmx_s[j-1];
			for (int i = 0; i < 3; i++) begin
				nm_s[j][i] <= hit ? (nm_s[j-1][i] << SH) : nm_s[j-1][i];
			end
			nneg_s[j]  <= nneg_s[j-1];
			nzero_s[j] <= nzero_s[j-1];
		end
	end

	// square stage
	logic [2*AW-1:0] sq_s [3];
	logic [AW-1:0]   a_s  [3];
	logic [2:0]      sqneg_s;
	logic            sqzero_s;
	logic            sqvld_s;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s[i]  <= nm_s[LVL][i][MW-1 -: AW];
			sq_s[i] <= nm_s[LVL][i][MW-1 -: AW] * nm_s[LVL][i][MW-1 -: AW];
		end
		sqneg_s  <= nneg_s[LVL];
		sqzero_s <= nzero_s[LVL];
	end

	// square-root stages: index 0 holds the sum
	logic [SW-1:0] rt_rem  [RW+1];
	logic [RW-1:0] rt_root [RW+1];
	logic [AW-1:0] rt_a    [RW+1][3];
	logic [2:0]    rt_neg  [RW+1];
	logic          rt_zero [RW+1];
	logic          rt_vld  [RW+1];

	always_ff @(posedge clk) begin
		rt_rem[0]  <= {2'b00, sq_s[0]} + {2'b00, sq_s[1]} + {2'b00, sq_s[2]};
		rt_root[0] <= '0;
		rt_a[0]    <= a_s;
		rt_neg[0]  <= sqneg_s;
		rt_zero[0] <= sqzero_s;
	end

	for (genvar j = 1; j <= RW; j++) begin : g_sqrt
		localparam int B = RW - j;
		logic [SW+1:0] trial;
		logic          ge;
		assign trial = ({{(SW+2-RW){1'b0}}, rt_root[j-1]} << (B + 1))
			| ((SW+2)'(1) << (2 * B));
		assign ge = {2'b00, rt_rem[j-1]} >= trial;
		always_ff @(posedge clk) begin
			rt_rem[j]  <= ge ? (rt_rem[j-1] - trial[SW-1:0]) : rt_rem[j-1];
			rt_root[j] <= ge ? (rt_root[j-1] | (RW'(1) << B)) : rt_root[j-1];
			rt_a[j]    <= rt_a[j-1];
			rt_neg[j]  <= rt_neg[j-1];
			rt_zero[j] <= rt_zero[j-1];
		end
	end

	// divide stages: index 0 holds the rounded dividends
	logic [DW-1:0] dv_rem  [DS+1][3];
	logic [QW-1:0] dv_q    [DS+1][3];
	logic [RW-1:0] dv_len  [DS+1];
	logic [2:0]    dv_neg  [DS+1];
	logic          dv_zero [DS+1];
	logic          dv_vld  [DS+1];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= {1'b0, rt_a[RW][i], {FRAC_BITS{1'b0}}}
				+ {{(DW-RW+1){1'b0}}, rt_root[RW][RW-1:1]};
			dv_q[0][i]   <= '0;
		end
		dv_len[0]  <= rt_root[RW];
		dv_neg[0]  <= rt_neg[RW];
		dv_zero[0] <= rt_zero[RW];
	end

	for (genvar j = 1; j <= DS; j++) begin : g_div
		localparam int B = DS - j;
		logic [DW-1:0] dvs;
		assign dvs = {{(DW-RW){1'b0}}, dv_len[j-1]} << B;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_rem[j-1][i] >= dvs) begin
					dv_rem[j][i] <= dv_rem[j-1][i] - dvs;
					dv_q[j][i]   <= dv_q[j-1][i] | (QW'(1) << B);
				end else begin
					dv_rem[j][i] <= dv_rem[j-1][i];
					dv_q[j][i]   <= dv_q[j-1][i];
				end
			end
			dv_len[j]  <= dv_len[j-1];
			dv_neg[j]  <= dv_neg[j-1];
			dv_zero[j] <= dv_zero[j-1];
		end
	end

	// sign stage
	logic signed [UW-1:0] u_s [3];
	logic                 ok_s;
	logic                 uvld_s;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero[DS]) begin
				u_s[i] <= '0;
			end else if (dv_neg[DS][i]) begin
				u_s[i] <= -$signed({1'b0, dv_q[DS][i]});
			end else begin
				u_s[i] <= $signed({1'b0, dv_q[DS][i]});
			end
		end
		ok_s <= !dv_zero[DS];
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			nvld_s  <= '{default: 1'b0};
			sqvld_s <= 1'b0;
			rt_vld  <= '{default: 1'b0};
			dv_vld  <= '{default: 1'b0};
			uvld_s  <= 1'b0;
		end else begin
			vld_s1    <= in_vld;
			vld_s2    <= vld_s1;
			nvld_s[0] <= vld_s2;
			for (int j = 1; j <= LVL; j++) begin
				nvld_s[j] <= nvld_s[j-1];
			end
			sqvld_s   <= nvld_s[LVL];
			rt_vld[0] <= sqvld_s;
			for (int j = 1; j <= RW; j++) begin
				rt_vld[j] <= rt_vld[j-1];
			end
			dv_vld[0] <= rt_vld[RW];
			for (int j = 1; j <= DS; j++) begin
				dv_vld[j] <= dv_vld[j-1];
			end
			uvld_s <= dv_vld[DS];
		end
	end

	assign out_vld = uvld_s;
	assign out_ok  = ok_s;
	assign ux      = u_s[0];
	assign uy      = u_s[1];
	assign uz      = u_s[2];

endmodule

`default_nettype wire

[hw/rtl/look_at_view_matrix.sv]
// Top level of the look-at view matrix pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | start & !busy        | pos_*, target_*, up_* (signed Q16.16)
//  output   | strobe per row       | row_index, col0..col3, degenerate, last_row
//
// An item is taken only while busy is low; busy rises after each transfer
// and holds while a spacing counter at the input runs down.
// The first row comes after the three normalizer passes, the cross products
// and the translation stages; rows 0..3 follow on consecutive cycles.
// The three chained normalizers (bitwise isqrt plus restoring divide) are
// the bulk of that path; items overlap freely inside the pipe.
// arst_n clears all valid bits and the output strobe; no clearing pass.
// The receiver cannot stall, so the pipe never holds.
`default_nettype none

module look_at_view_matrix #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic signed [31:0] target_z,
	input  wire logic signed [31:0] up_x,
	input  wire logic signed [31:0] up_y,
	input  wire logic signed [31:0] up_z,
	output logic                    strobe,
	output logic [1:0]              row_index,
	output logic signed [31:0]      col0,
	output logic signed [31:0]      col1,
	output logic signed [31:0]      col2,
	output logic signed [31:0]      col3,
	output logic                    degenerate,
	output logic                    last_row
);

	localparam int U  = lvm_pkg::unit_lat(FRAC_BITS);
	localparam int UW = FRAC_BITS + 2;      // unit vector component
	localparam int PW = 2 * UW;             // cross product component
	localparam int VW = 3 * UW;             // packed unit vector
	localparam int TW = UW + 34;            // translation dot product
	localparam int FL = 2 * U + 4;          // forward axis delay
	localparam int RL = U + 2;              // right axis delay
	localparam int PL = 3 * U + 4;          // position delay

	// ---------------- input transfer and spacing ----------------
	logic       acc;
	logic [1:0] gap_q;

	assign acc  = start && !busy;
	assign busy = (gap_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (acc) begin
			gap_q <= lvm_pkg::GAP_LAST;
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// stage 1: register position, view direction and up vector
	logic signed [31:0] p_s1 [3];
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] up_s1 [3];
	logic               vld_s1;

	always_ff @(posedge clk) begin
		p_s1[0]  <= pos_x;
		p_s1[1]  <= pos_y;
		p_s1[2]  <= pos_z;
		d_s1[0]  <= {pos_x[31], pos_x} - {target_x[31], target_x};
		d_s1[1]  <= {pos_y[31], pos_y} - {target_y[31], target_y};
		d_s1[2]  <= {pos_z[31], pos_z} - {target_z[31], target_z};
		up_s1[0] <= up_x;
		up_s1[1] <= up_y;
		up_s1[2] <= up_z;
	end

	// ---------------- forward and normalized up ----------------
	logic signed [UW-1:0] f_v [3];
	logic signed [UW-1:0] nu_v [3];
	logic                 fa_vld, fa_ok, nb_vld, nb_ok;

	lvm_unit3 #(.FRAC_BITS(FRAC_BITS), .IW(33)) u_fwd (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.vx(d_s1[0]), .vy(d_s1[1]), .vz(d_s1[2]),
		.out_vld(fa_vld), .out_ok(fa_ok),
		.ux(f_v[0]), .uy(f_v[1]), .uz(f_v[2])
	);

	lvm_unit3 #(.FRAC_BITS(FRAC_BITS), .IW(32)) u_wup (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.vx(up_s1[0]), .vy(up_s1[1]), .vz(up_s1[2]),
		.out_vld(nb_vld), .out_ok(nb_ok),
		.ux(nu_v[0]), .uy(nu_v[1]), .uz(nu_v[2])
	);

	// ---------------- cross(nu, f): multiply, then subtract ----------------
	logic signed [PW-1:0] x1p_s1 [6];
	logic signed [PW-1:0] x1c_s2 [3];
	logic                 x1_vld_s1, x1_vld_s2;

	always_ff @(posedge clk) begin
		x1p_s1[0] <= nu_v[1] * f_v[2];
		x1p_s1[1] <= nu_v[2] * f_v[1];
		x1p_s1[2] <= nu_v[2] * f_v[0];
		x1p_s1[3] <= nu_v[0] * f_v[2];
		x1p_s1[4] <= nu_v[0] * f_v[1];
		x1p_s1[5] <= nu_v[1] * f_v[0];
		x1c_s2[0] <= x1p_s1[0] - x1p_s1[1];
		x1c_s2[1] <= x1p_s1[2] - x1p_s1[3];
		x1c_s2[2] <= x1p_s1[4] - x1p_s1[5];
	end

	// forward axis and its flag ride along until the translation stage
	logic [VW:0] f_line_q [FL];

	always_ff @(posedge clk) begin
		f_line_q[0] <= {fa_ok && nb_ok, f_v[2], f_v[1], f_v[0]};
		for (int k = 1; k < FL; k++) begin
			f_line_q[k] <= f_line_q[k-1];
		end
	end

	// ---------------- right axis ----------------
	logic signed [UW-1:0] r_v [3];
	logic                 rc_vld, rc_ok;

	lvm_unit3 #(.FRAC_BITS(FRAC_BITS), .IW(PW)) u_rgt (
		.clk(clk), .arst_n(arst_n), .in_vld(x1_vld_s2),
		.vx(x1c_s2[0]), .vy(x1c_s2[1]), .vz(x1c_s2[2]),
		.out_vld(rc_vld), .out_ok(rc_ok),
		.ux(r_v[0]), .uy(r_v[1]), .uz(r_v[2])
	);

	// forward axis tapped in step with the right axis
	logic signed [UW-1:0] ft_v [3];
	for (genvar i = 0; i < 3; i++) begin : g_ftap
		assign ft_v[i] = $signed(f_line_q[U+1][i*UW +: UW]);
	end

	// ---------------- cross(f, r) ----------------
	logic signed [PW-1:0] x2p_s1 [6];
	logic signed [PW-1:0] x2c_s2 [3];
	logic                 x2_vld_s1, x2_vld_s2;

	always_ff @(posedge clk) begin
		x2p_s1[0] <= ft_v[1] * r_v[2];
		x2p_s1[1] <= ft_v[2] * r_v[1];
		x2p_s1[2] <= ft_v[2] * r_v[0];
		x2p_s1[3] <= ft_v[0] * r_v[2];
		x2p_s1[4] <= ft_v[0] * r_v[1];
		x2p_s1[5] <= ft_v[1] * r_v[0];
		x2c_s2[0] <= x2p_s1[0] - x2p_s1[1];
		x2c_s2[1] <= x2p_s1[2] - x2p_s1[3];
		x2c_s2[2] <= x2p_s1[4] - x2p_s1[5];
	end

	logic [VW:0] r_line_q [RL];

	always_ff @(posedge clk) begin
		r_line_q[0] <= {rc_ok, r_v[2], r_v[1], r_v[0]};
		for (int k = 1; k < RL; k++) begin
			r_line_q[k] <= r_line_q[k-1];
		end
	end

	// ---------------- camera up axis ----------------
	logic signed [UW-1:0] u_v [3];
	logic                 ud_vld, ud_ok;

	lvm_unit3 #(.FRAC_BITS(FRAC_BITS), .IW(PW)) u_cup (
		.clk(clk), .arst_n(arst_n), .in_vld(x2_vld_s2),
		.vx(x2c_s2[0]), .vy(x2c_s2[1]), .vz(x2c_s2[2]),
		.out_vld(ud_vld), .out_ok(ud_ok),
		.ux(u_v[0]), .uy(u_v[1]), .uz(u_v[2])
	);

	// position follows the whole chain
	logic [95:0] p_line_q [PL];

	always_ff @(posedge clk) begin
		p_line_q[0] <= {p_s1[2], p_s1[1], p_s1[0]};
		for (int k = 1; k < PL; k++) begin
			p_line_q[k] <= p_line_q[k-1];
		end
	end

	// aligned axes: row 0 right, row 1 camera up, row 2 forward
	logic signed [UW-1:0] ax [3][3];
	logic signed [31:0]   pd [3];
	logic                 all_ok;

	for (genvar i = 0; i < 3; i++) begin : g_axes
		assign ax[0][i] = $signed(r_line_q[RL-1][i*UW +: UW]);
		assign ax[1][i] = u_v[i];
		assign ax[2][i] = $signed(f_line_q[FL-1][i*UW +: UW]);
		assign pd[i]    = $signed(p_line_q[PL-1][i*32 +: 32]);
	end
	assign all_ok = f_line_q[FL-1][VW] && r_line_q[RL-1][VW] && ud_ok;

	// ---------------- translation: products, sum, magnitude, round ----------------
	logic signed [UW+31:0] tp_s1 [3][3];
	logic signed [TW-1:0]  ts_s2 [3];
	logic [TW-1:0]         tm_s3 [3];
	logic [2:0]            tn_s3;
	logic signed [31:0]    tr_s4 [3];
	logic signed [UW-1:0]  rot_s1 [3][3];
	logic signed [UW-1:0]  rot_s2 [3][3];
	logic signed [UW-1:0]  rot_s3 [3][3];
	logic signed [31:0]    rot_s4 [3][3];
	logic                  ok_s1, ok_s2, ok_s3, ok_s4;
	logic                  tvld_s1, tvld_s2, tvld_s3, tvld_s4;

	logic [TW:0]        rnd [3];
	logic [TW-FRAC_BITS:0] rr [3];
	logic signed [31:0] sat [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = {1'b0, tm_s3[k]} + ((TW+1)'(1) << (FRAC_BITS - 1));
			rr[k]  = rnd[k][TW:FRAC_BITS];
			if (tn_s3[k]) begin
				// dot was negative: -round(dot) is positive
				sat[k] = (rr[k] > (TW-FRAC_BITS+1)'(32'h7fff_ffff))
					? 32'sh7fff_ffff : $signed(rr[k][31:0]);
			end else begin
				sat[k] = (rr[k] > (TW-FRAC_BITS+1)'(32'h8000_0000))
					? 32'sh8000_0000 : -$signed(rr[k][31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				tp_s1[k][i]  <= ax[k][i] * pd[i];
				rot_s1[k][i] <= ax[k][i];
			end
			ts_s2[k] <= {{2{tp_s1[k][0][UW+31]}}, tp_s1[k][0]}
				+ {{2{tp_s1[k][1][UW+31]}}, tp_s1[k][1]}
				+ {{2{tp_s1[k][2][UW+31]}}, tp_s1[k][2]};
			tn_s3[k] <= ts_s2[k][TW-1];
			tm_s3[k] <= ts_s2[k][TW-1] ? -ts_s2[k] : ts_s2[k];
			tr_s4[k] <= ok_s3 ? sat[k] : 32'sd0;
			for (int i = 0; i < 3; i++) begin
				rot_s4[k][i] <= ok_s3
					? {{(32-UW){rot_s3[k][i][UW-1]}}, rot_s3[k][i]} : 32'sd0;
			end
		end
		rot_s2 <= rot_s1;
		rot_s3 <= rot_s2;
		ok_s1  <= all_ok;
		ok_s2  <= ok_s1;
		ok_s3  <= ok_s2;
		ok_s4  <= ok_s3;
	end

	// ---------------- row serializer ----------------
	logic signed [31:0] hold_q [2][4];
	logic               deg_q;
	logic [1:0]         cnt_q;
	logic               act_q;
	logic               stb_q;
	logic [1:0]         row_q;
	logic signed [31:0] c_q [4];
	logic               dg_q;

	always_ff @(posedge clk) begin
		if (tvld_s4) begin
			for (int k = 0; k < 2; k++) begin
				for (int i = 0; i < 3; i++) begin
					hold_q[k][i] <= rot_s4[k+1][i];
				end
				hold_q[k][3] <= tr_s4[k+1];
			end
			deg_q  <= !ok_s4;
			row_q  <= lvm_pkg::ROW_0;
			c_q[0] <= rot_s4[0][0];
			c_q[1] <= rot_s4[0][1];
			c_q[2] <= rot_s4[0][2];
			c_q[3] <= tr_s4[0];
			dg_q   <= !ok_s4;
		end else if (act_q) begin
			row_q <= cnt_q;
			dg_q  <= deg_q;
			case (cnt_q)
				lvm_pkg::ROW_1: c_q <= hold_q[0];
				lvm_pkg::ROW_2: c_q <= hold_q[1];
				default: begin
					c_q[0] <= '0;
					c_q[1] <= '0;
					c_q[2] <= '0;
					c_q[3] <= 32'sd1 <<< FRAC_BITS;
				end
			endcase
		end
	end

	// ---------------- control: valid bits and serializer state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			x1_vld_s1 <= 1'b0;
			x1_vld_s2 <= 1'b0;
			x2_vld_s1 <= 1'b0;
			x2_vld_s2 <= 1'b0;
			tvld_s1   <= 1'b0;
			tvld_s2   <= 1'b0;
			tvld_s3   <= 1'b0;
			tvld_s4   <= 1'b0;
			act_q     <= 1'b0;
			cnt_q     <= lvm_pkg::ROW_0;
			stb_q     <= 1'b0;
		end else begin
			vld_s1    <= acc;
			x1_vld_s1 <= fa_vld;
			x1_vld_s2 <= x1_vld_s1;
			x2_vld_s1 <= rc_vld;
			x2_vld_s2 <= x2_vld_s1;
			tvld_s1   <= ud_vld;
			tvld_s2   <= tvld_s1;
			tvld_s3   <= tvld_s2;
			tvld_s4   <= tvld_s3;
			if (tvld_s4) begin
				act_q <= 1'b1;
				cnt_q <= lvm_pkg::ROW_1;
				stb_q <= 1'b1;
			end else if (act_q) begin
				stb_q <= 1'b1;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == lvm_pkg::ROW_3) begin
					act_q <= 1'b0;
				end
			end else begin
				stb_q <= 1'b0;
			end
		end
	end

	assign strobe     = stb_q;
	assign row_index  = row_q;
	assign col0       = c_q[0];
	assign col1       = c_q[1];
	assign col2       = c_q[2];
	assign col3       = c_q[3];
	assign degenerate = dg_q;
	assign last_row   = (row_q == lvm_pkg::ROW_3);

	// ---------------- assertions ----------------
	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		fa_vld == nb_vld)
		else $error("forward and up normalizers out of step");

	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && row_index == lvm_pkg::ROW_0 |=> strobe && row_index == lvm_pkg::ROW_1)
		else $error("row 1 did not follow row 0");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && degenerate && row_index != lvm_pkg::ROW_3 |->
		col0 == 32'sd0 && col1 == 32'sd0 && col2 == 32'sd0 && col3 == 32'sd0)
		else $error("degenerate row carries nonzero entries");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

endmodule

`default_nettype wire

[tb/sv/look_at_view_matrix_tb.sv]
// Testbench for the look-at view matrix block: directed table plus random items.
`timescale 1ns / 100ps

module look_at_view_matrix_tb;

	localparam int  FB         = lvm_pkg::FRAC_BITS_DEF;
	localparam int  ONE        = 1 << FB;
	// hang guard limit on the whole run, far above what the items and the pipe drain need
	localparam int  CYCLE_CAP  = 200000;
	// extra wait once every queued row is checked, before the verdict
	localparam int  PIPE_LAT   = 3 * lvm_pkg::unit_lat(FB) + 10;

	typedef longint vec3_t [3];

	typedef struct {
		logic [1:0]         row;
		logic signed [31:0] c0, c1, c2, c3;
		logic               degen;
		logic               last;
	} matrix_row_t;

	// one row of the directed table; degen_known rows carry a typed-in result
	typedef struct {
		logic signed [31:0] px, py, pz, tx, ty, tz, ux, uy, uz;
		bit                 degen_known;
	} view_item_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [31:0] target_x, target_y, target_z;
	logic signed [31:0] up_x, up_y, up_z;
	logic               strobe;
	logic [1:0]         row_index;
	logic signed [31:0] col0, col1, col2, col3;
	logic               degenerate;
	logic               last_row;

	matrix_row_t rows_due[$];
	int          mismatches;
	int          cycles;
	int          idle_pct;

	look_at_view_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.strobe(strobe), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.degenerate(degenerate), .last_row(last_row)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor: fixed-point look-at, same rounding as the datapath
	// ---------------------------------------------------------------

	// bitwise integer square root, floor
	function automatic bit [63:0] int_sqrt(input bit [63:0] x);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// normalize to FB fraction bits; returns 0 for a zero vector
	function automatic bit normalize(input vec3_t v, output vec3_t u);
		bit [63:0] m [3];
		bit [63:0] mx, sq, len, q;
		bit        ng [3];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			ng[i] = v[i] < 0;
			m[i]  = ng[i] ? 64'(-v[i]) : 64'(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			u = '{0, 0, 0};
			return 1'b0;
		end
		// bring the largest magnitude into [2^30, 2^31)
		while (mx >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		sq  = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q    = ((m[i] << FB) + (len >> 1)) / len;
			u[i] = ng[i] ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic vec3_t cross_prod(input vec3_t a, input vec3_t b);
		vec3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	// -round(dot(axis, pos)), half away from zero, saturated to 32 bits
	function automatic logic signed [31:0] translation(input vec3_t ax, input vec3_t p);
		longint    s;
		bit        ng;
		bit [63:0] mag, r;
		s   = ax[0] * p[0] + ax[1] * p[1] + ax[2] * p[2];
		ng  = s < 0;
		mag = ng ? 64'(-s) : 64'(s);
		r   = (mag + (64'd1 << (FB - 1))) >> FB;
		if (ng)
			return (r > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(r);
		return (r > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(r));
	endfunction

	// queue the four rows for one transferred item
	task automatic predict_matrix(input view_item_t it);
		vec3_t       p, d, up, fwd, nup, rgt, cup;
		vec3_t       axes [3];
		bit          ok;
		matrix_row_t r;
		p  = '{it.px, it.py, it.pz};
		d  = '{longint'(it.px) - it.tx, longint'(it.py) - it.ty, longint'(it.pz) - it.tz};
		up = '{it.ux, it.uy, it.uz};
		ok = normalize(d, fwd);
		ok = normalize(up, nup) & ok;
		ok = normalize(cross_prod(nup, fwd), rgt) & ok;
		ok = normalize(cross_prod(fwd, rgt), cup) & ok;
		axes[0] = rgt;
		axes[1] = cup;
		axes[2] = fwd;
		for (int k = 0; k < 3; k++) begin
			r.row   = 2'(k);
			r.c0    = ok ? 32'(axes[k][0]) : '0;
			r.c1    = ok ? 32'(axes[k][1]) : '0;
			r.c2    = ok ? 32'(axes[k][2]) : '0;
			r.c3    = ok ? translation(axes[k], p) : '0;
			r.degen = !ok;
			r.last  = 1'b0;
			rows_due.push_back(r);
		end
		r = '{lvm_pkg::ROW_3, 0, 0, 0, ONE, !ok, 1'b1};
		rows_due.push_back(r);
	endtask

	// degenerate matrix, read straight off the spec
	task automatic push_degenerate();
		rows_due.push_back('{lvm_pkg::ROW_0, 0, 0, 0, 0, 1'b1, 1'b0});
		rows_due.push_back('{lvm_pkg::ROW_1, 0, 0, 0, 0, 1'b1, 1'b0});
		rows_due.push_back('{lvm_pkg::ROW_2, 0, 0, 0, 0, 1'b1, 1'b0});
		rows_due.push_back('{lvm_pkg::ROW_3, 0, 0, 0, ONE, 1'b1, 1'b1});
	endtask

	// ---------------------------------------------------------------
	// Driver: one transfer per call, with an optional idle gap first
	// ---------------------------------------------------------------
	task automatic send_item(input view_item_t it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pos_x    <= it.px;
		pos_y    <= it.py;
		pos_z    <= it.pz;
		target_x <= it.tx;
		target_y <= it.ty;
		target_z <= it.tz;
		up_x     <= it.ux;
		up_y     <= it.uy;
		up_z     <= it.uz;
		start    <= 1'b1;
		// busy sampled here is the pre-edge value, so this edge is the transfer
		do
			@(posedge clk);
		while (busy);
		if (it.degen_known)
			push_degenerate();
		else
			predict_matrix(it);
	endtask

	// random coordinate: mostly moderate, sometimes full range, zero or tiny
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9))
			0:       return '0;
			1, 2:    return $urandom;
			3:       return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic view_item_t rand_item();
		view_item_t   it;
		int           kind;
		logic signed [31:0] dx, dy, dz, k;
		it   = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0};
		kind = $urandom_range(19);
		if (kind == 0) begin
			// looking at its own position
			it.tx = it.px;
			it.ty = it.py;
			it.tz = it.pz;
		end else if (kind == 1) begin
			// up is a multiple of the view direction
			dx    = $signed($urandom_range(0, 20)) - 10;
			dy    = $signed($urandom_range(0, 20)) - 10;
			dz    = $signed($urandom_range(1, 10));
			k     = $urandom_range(1) ? 32'sd3 : -32'sd2;
			it.tx = $signed($urandom_range(0, 200)) - 100;
			it.ty = $signed($urandom_range(0, 200)) - 100;
			it.tz = $signed($urandom_range(0, 200)) - 100;
			it.px = it.tx + (dx << FB);
			it.py = it.ty + (dy << FB);
			it.pz = it.tz + (dz << FB);
			it.ux = (dx * k) << FB;
			it.uy = (dy * k) << FB;
			it.uz = (dz * k) << FB;
		end else if (kind == 2) begin
			it.ux = 0;
			it.uy = 0;
			it.uz = 0;
		end
		return it;
	endfunction

	// directed rows: degenerate cases, axis-aligned camera, extremes
	view_item_t directed [17] = '{
		'{0, 0, 0, 0, 0, 0, 0, ONE, 0, 1'b1},                      // eye on target
		'{ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 1'b1},              // zero up
		'{0, 0, ONE, 0, 0, 0, 0, 0, ONE, 1'b1},                    // up along forward
		'{0, 0, ONE, 0, 0, 0, 0, 0, -5*ONE, 1'b1},                 // up against forward
		'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, ONE, 0, 1'b1},
		'{0, 0, ONE, 0, 0, 0, 0, ONE, 0, 1'b0},                    // identity-like
		'{0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0, 1'b0},
		'{3*ONE, 4*ONE, 5*ONE, ONE, 0, -ONE, 0, ONE, 0, 1'b0},
		'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, ONE, 0, 0, 1'b0},
		'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0},
		'{32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0, 0, 0, 32'sh7fff_ffff, 1'b0},
		'{0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0,
			32'sh7fff_ffff, 32'sh8000_0000, 1, 1'b0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0},                        // tiny vectors
		'{-1, -1, -1, 0, 0, 0, 0, -1, 0, 1'b0},
		'{32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa,
			32'sh1234_5678, 32'sh8765_4321, 32'sh0f0f_0f0f,
			32'shf0f0_f0f0, 32'sh3333_3333, 32'shcccc_cccc, 1'b0},
		'{10*ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, 1'b0},
		'{0, 100*ONE, 0, 0, 0, 0, 0, 0, ONE, 1'b0}
	};

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		mismatches = 0;
		idle_pct   = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		{pos_x, pos_y, pos_z}          = '0;
		{target_x, target_y, target_z} = '0;
		{up_x, up_y, up_z}             = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i]);

		// four idling phases; the receiver cannot stall, so only the sender idles
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       idle_pct = 0;
				1:       idle_pct = 62;
				2:       idle_pct = 0;
				default: idle_pct = 33;
			endcase
			repeat (91)
				send_item(rand_item());
		end
		start <= 1'b0;

		wait (rows_due.size() == 0);
		repeat (PIPE_LAT) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result checker: every strobe must match the oldest queued row
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input longint exp, input longint act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		matrix_row_t e;
		if (arst_n && strobe) begin
			if (rows_due.size() == 0) begin
				$error("row_index: expected none, got %0d", row_index);
				mismatches++;
			end else begin
				e = rows_due.pop_front();
				check_field("row_index", e.row, row_index);
				check_field("col0", e.c0, col0);
				check_field("col1", e.c1, col1);
				check_field("col2", e.c2, col2);
				check_field("col3", e.c3, col3);
				check_field("degenerate", e.degen, degenerate);
				check_field("last_row", e.last, last_row);
			end
		end
	end

	// hang guard
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

[sim.f]
hw/rtl/lvm_pkg.sv
hw/rtl/lvm_unit3.sv
hw/rtl/look_at_view_matrix.sv
tb/sv/look_at_view_matrix_tb.sv
